FILE: src/vdt_pkg.sv
// vdt_pkg: shared constants, types and helper functions for the vertex dedup table.
// No dependencies.
package vdt_pkg;

   localparam int MAX_UNIQUE = 1024;
   localparam int ADDR_W     = $clog2(MAX_UNIQUE);
   localparam int COUNT_W    = $clog2(MAX_UNIQUE + 1);
   localparam int COORD_W    = 64;
   localparam int INDEX_W    = 10;

   localparam logic [COORD_W-1:0] EXP_MASK  = 64'h7FF0_0000_0000_0000;
   localparam logic [COORD_W-1:0] FRAC_MASK = 64'h000F_FFFF_FFFF_FFFF;
   localparam logic [COORD_W-1:0] MAG_MASK  = 64'h7FFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic                   start_of_mesh;
      logic [COORD_W-1:0]     coord_x;
      logic [COORD_W-1:0]     coord_y;
      logic [COORD_W-1:0]     coord_z;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] merged_index;
      logic               is_new;
      logic               table_full;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CMP,
      ST_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;      // capture request, clear count if start flag
      logic addr_zero; // scan address to 0
      logic addr_inc;  // advance scan address
      logic emit_hit;  // result: matched entry
      logic emit_new;  // result: insert at count
      logic emit_full; // result: table full
      logic write;     // write stores at count
   } ctl_type;

   // datapath -> controller
   typedef struct packed {
      logic scan_end;  // scan address reached count
      logic match;     // registered read data matches
      logic full;      // count at capacity
   } sts_type;

   function automatic logic is_nan(input logic [COORD_W-1:0] a);
      return ((a & EXP_MASK) == EXP_MASK) && ((a & FRAC_MASK) != '0);
   endfunction

   function automatic logic coord_eq(input logic [COORD_W-1:0] a,
                                     input logic [COORD_W-1:0] b);
      if (is_nan(a) || is_nan(b)) return 1'b0;
      if (((a & MAG_MASK) == '0) && ((b & MAG_MASK) == '0)) return 1'b1;
      return a == b;
   endfunction

endpackage

FILE: src/vdt_stream_if.sv
// vdt_stream_if: valid/ready channel carrying a generic payload type.
// No dependencies; the payload type is supplied as a parameter.
interface vdt_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: src/vdt_ram.sv
// vdt_ram: generic single-port RAM, registered read.
// No dependencies.
module vdt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[addr] <= wr_data;
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: src/vdt_datapath.sv
// vdt_datapath: request register, scan address, unique count, coordinate stores,
// compare and result register. Depends on vdt_pkg and vdt_ram.
module vdt_datapath (
   input  logic              clock,
   input  logic              reset,
   input  vdt_pkg::req_type  req_data,
   input  vdt_pkg::ctl_type  ctl,
   output vdt_pkg::sts_type  sts,
   output vdt_pkg::rsp_type  rsp_data
);
   import vdt_pkg::*;

   req_type            req_ff;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] scan_ff, scan_in;
   rsp_type            rsp_ff, rsp_in;
   logic [ADDR_W-1:0]  ram_addr;
   logic [COORD_W-1:0] rd_x, rd_y, rd_z;

   assign ram_addr = ctl.write ? count_ff[ADDR_W-1:0] : scan_ff[ADDR_W-1:0];

   vdt_ram #(.WIDTH(COORD_W), .DEPTH(MAX_UNIQUE)) u_x_ram (
      .clock, .wr_en(ctl.write), .addr(ram_addr), .wr_data(req_ff.coord_x),
      .rd_data(rd_x));
   vdt_ram #(.WIDTH(COORD_W), .DEPTH(MAX_UNIQUE)) u_y_ram (
      .clock, .wr_en(ctl.write), .addr(ram_addr), .wr_data(req_ff.coord_y),
      .rd_data(rd_y));
   vdt_ram #(.WIDTH(COORD_W), .DEPTH(MAX_UNIQUE)) u_z_ram (
      .clock, .wr_en(ctl.write), .addr(ram_addr), .wr_data(req_ff.coord_z),
      .rd_data(rd_z));

   always_comb begin
      count_in = count_ff;
      scan_in  = scan_ff;
      rsp_in   = rsp_ff;
      if (ctl.load && req_data.start_of_mesh) count_in = '0;
      if (ctl.addr_zero) scan_in = '0;
      else if (ctl.addr_inc) scan_in = scan_ff + COUNT_W'(1);
      if (ctl.emit_hit) begin
         rsp_in.merged_index = INDEX_W'(scan_ff - COUNT_W'(1));
         rsp_in.is_new       = 1'b0;
         rsp_in.table_full   = 1'b0;
      end else if (ctl.emit_new) begin
         rsp_in.merged_index = INDEX_W'(count_ff);
         rsp_in.is_new       = 1'b1;
         rsp_in.table_full   = 1'b0;
         count_in            = count_ff + COUNT_W'(1);
      end else if (ctl.emit_full) begin
         rsp_in.merged_index = '0;
         rsp_in.is_new       = 1'b0;
         rsp_in.table_full   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         scan_ff  <= '0;
      end else begin
         count_ff <= count_in;
         scan_ff  <= scan_in;
      end
      if (ctl.load) req_ff <= req_data;
      rsp_ff <= rsp_in;
   end

   assign sts.scan_end  = (scan_ff == count_ff);
   assign sts.full      = (count_ff == COUNT_W'(MAX_UNIQUE));
   assign sts.match     = coord_eq(rd_x, req_ff.coord_x) &&
                          coord_eq(rd_y, req_ff.coord_y) &&
                          coord_eq(rd_z, req_ff.coord_z);
   assign rsp_data      = rsp_ff;
endmodule

FILE: src/vdt_ctrl.sv
// vdt_ctrl: sequencer for scan, insert and response handshake.
// Depends on vdt_pkg.
module vdt_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  vdt_pkg::sts_type sts,
   output vdt_pkg::ctl_type ctl
);
   import vdt_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // Scan: READ issues address a (scan -> a+1), CMP checks data of a.
   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.load      = 1'b1;
               ctl.addr_zero = 1'b1;
               state_in      = ST_READ;
            end
         end
         ST_READ: begin
            if (sts.scan_end) begin
               if (sts.full) ctl.emit_full = 1'b1;
               else          ctl.write     = 1'b1;
               if (!sts.full) ctl.emit_new = 1'b1;
               state_in = ST_DONE;
            end else begin
               ctl.addr_inc = 1'b1;
               state_in     = ST_CMP;
            end
         end
         ST_CMP: begin
            if (sts.match) begin
               ctl.emit_hit = 1'b1;
               state_in     = ST_DONE;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end
endmodule

FILE: src/vertex_dedup_table.sv
// vertex_dedup_table: top level, joins the controller and the datapath.
// Depends on vdt_pkg, vdt_stream_if, vdt_ctrl, vdt_datapath.
//
// Vertex dedup table. Each request carries one vertex (x, y, z as IEEE double
// bit patterns) and yields one response: the index of the first stored vertex
// with an equal position, or a fresh index (is_new) when none matches, counted
// from 0 in order of first appearance. +0 equals -0; NaN never matches.
// start_of_mesh clears the table first. With 1024 entries stored, an unmatched
// vertex returns table_full with index 0 and is not stored. The search is a
// linear scan of the stored entries through single-port RAMs with a registered
// read. An unmatched request goes through accept, scan, insert or full, and
// response; every response is held until ready.
// One request is processed at a time.
module vertex_dedup_table (
   input logic clock,
   input logic reset,
   vdt_stream_if.sink   req,
   vdt_stream_if.source rsp
);
   import vdt_pkg::*;

   ctl_type ctl;
   sts_type sts;

   vdt_ctrl u_ctrl (
      .clock, .reset,
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .sts, .ctl
   );

   vdt_datapath u_dp (
      .clock, .reset,
      .req_data(req.data), .ctl, .sts, .rsp_data(rsp.data)
   );
endmodule

FILE: sim/vertex_dedup_table_tb.sv
`timescale 1ns / 100ps
// vertex_dedup_table_tb: self-checking bench for the vertex dedup table.
// Depends on vdt_pkg, vdt_stream_if and vertex_dedup_table from src.
// Random vertices come from a small coordinate pool, so repeats, signed zeros and NaNs
// are common; a scoreboard class predicts each response and checks it in order.

module vertex_dedup_table_tb;
   import vdt_pkg::*;

   localparam int CLK_HALF    = 4;
   localparam int CYCLE_LIMIT = 40000000;

   // Scoreboard: a private copy of the unique vertex table plus the queue of
   // responses expected in order.
   class dedup_scoreboard;
      logic [COORD_W-1:0] pos_x[MAX_UNIQUE];
      logic [COORD_W-1:0] pos_y[MAX_UNIQUE];
      logic [COORD_W-1:0] pos_z[MAX_UNIQUE];
      int                 stored;
      rsp_type            pending_rsp[$];
      int                 errors;
      int                 n_new, n_hit, n_full;

      function automatic bit nan_bits(logic [COORD_W-1:0] a);
         return a[62:52] == 11'h7FF && a[51:0] != 0;
      endfunction

      function automatic bit same_coord(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b);
         if (nan_bits(a) || nan_bits(b)) return 0;
         if (a[62:0] == 0 && b[62:0] == 0) return 1;
         return a == b;
      endfunction

      function automatic void note_request(req_type r);
         rsp_type e;
         int      hit;
         hit = -1;
         if (r.start_of_mesh) stored = 0;
         for (int i = 0; i < stored && hit < 0; i++)
            if (same_coord(pos_x[i], r.coord_x) && same_coord(pos_y[i], r.coord_y) &&
                same_coord(pos_z[i], r.coord_z))
               hit = i;
         e = '0;
         if (hit >= 0) begin
            e.merged_index = hit[INDEX_W-1:0];
            n_hit++;
         end else if (stored >= MAX_UNIQUE) begin
            e.table_full = 1'b1;
            n_full++;
         end else begin
            pos_x[stored] = r.coord_x;
            pos_y[stored] = r.coord_y;
            pos_z[stored] = r.coord_z;
            e.merged_index = stored[INDEX_W-1:0];
            e.is_new = 1'b1;
            stored++;
            n_new++;
         end
         pending_rsp = {pending_rsp, e};
      endfunction

      function automatic void check_response(rsp_type got);
         rsp_type e;
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected response %p", $time, got);
            errors++;
            return;
         end
         e = pending_rsp.pop_front();
         if (got.merged_index !== e.merged_index) begin
            $display("%0t: merged_index expected %0d got %0d", $time, e.merged_index,
                     got.merged_index);
            errors++;
         end
         if (got.is_new !== e.is_new) begin
            $display("%0t: is_new expected %0b got %0b", $time, e.is_new, got.is_new);
            errors++;
         end
         if (got.table_full !== e.table_full) begin
            $display("%0t: table_full expected %0b got %0b", $time, e.table_full,
                     got.table_full);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   vdt_stream_if #(.payload_type(req_type)) req_ch ();
   vdt_stream_if #(.payload_type(rsp_type)) rsp_ch ();

   vertex_dedup_table i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   dedup_scoreboard board;
   longint unsigned cycles;
   int              hold_cycles;  // long receiver hold-off requested by the driver

   // Coordinate pool: a few values incl. +0, -0, NaNs and infinities so
   // positions repeat often; occasionally a fully random pattern.
   logic [COORD_W-1:0] coord_pool[16];

   initial begin
      clock = 1'b0;
      forever begin
         #CLK_HALF clock = 1'b1;
         #CLK_HALF clock = 1'b0;
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Short gaps mostly, a long one now and then.
   function automatic int gap_len();
      if ($urandom_range(0, 9) < 4) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
      return $urandom_range(1, 3);
   endfunction

   // Response side: accepts at random, honors a requested long hold-off.
   initial begin
      int gap;
      rsp_ch.ready = 1'b0;
      @(posedge clock);
      while (1) begin
         if (hold_cycles > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end
         gap = gap_len();
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         board.check_response(rsp_ch.data);
      end
   end

   // Holds one request on the channel until accepted, then notes it.
   task automatic send_vertex(input logic som, input logic [COORD_W-1:0] x,
                              input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z,
                              input bit no_gap = 0);
      req_type r;
      int      gap;
      r.start_of_mesh = som;
      r.coord_x = x;
      r.coord_y = y;
      r.coord_z = z;
      gap = no_gap ? 0 : gap_len();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= r;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      board.note_request(r);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (board.pending_rsp.size() != 0) @(posedge clock);
   endtask

   function automatic logic [COORD_W-1:0] pick_coord();
      if ($urandom_range(0, 15) == 0) return {$urandom, $urandom};
      return coord_pool[$urandom_range(0, 15)];
   endfunction

   initial begin
      logic [COORD_W-1:0] cx, cy, cz;
      board = new();
      cycles = 0;
      hold_cycles = 0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      coord_pool = '{64'h0, 64'h8000_0000_0000_0000, 64'h7FF8_0000_0000_0000,
                     64'hFFF0_0000_0000_0001, 64'h7FF0_0000_0000_0000,
                     64'hFFF0_0000_0000_0000, 64'h3FF0_0000_0000_0000,
                     64'hBFF0_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
                     64'h7FEF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001,
                     64'h8000_0000_0000_0001, 64'h4000_0000_0000_0000,
                     64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                     64'h3FF0_0000_0000_0001};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: signed zeros merge, NaN never merges, extremes, start flag.
      send_vertex(1'b0, 64'h0, 64'h0, 64'h0);
      send_vertex(1'b0, 64'h8000_0000_0000_0000, 64'h0, 64'h8000_0000_0000_0000);
      send_vertex(1'b0, 64'h7FF8_0000_0000_0000, 64'h0, 64'h0);
      send_vertex(1'b0, 64'h7FF8_0000_0000_0000, 64'h0, 64'h0);
      send_vertex(1'b0, '1, '1, '1);
      send_vertex(1'b0, '1, '1, '1);
      send_vertex(1'b0, 64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000, 64'h1);
      send_vertex(1'b0, 64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000, 64'h1);
      send_vertex(1'b0, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 64'h0);
      send_vertex(1'b1, '1, '1, '1);
      send_vertex(1'b0, 64'h0, 64'h0, 64'h0);
      send_vertex(1'b0, '1, '1, '1);

      // Fill the table to capacity, then probe full, hits and NaN while full.
      // Receiver holds off once early in the fill so the input stalls behind it.
      hold_cycles = 300;
      send_vertex(1'b1, 64'h0, 64'h0, 64'h0, 1);
      for (int i = 1; i < MAX_UNIQUE; i++)
         send_vertex(1'b0, {32'h4000_0000, i[31:0]}, {$urandom, $urandom}, 64'h0, 1);
      send_vertex(1'b0, 64'h1234, 64'h5678, 64'h9ABC);
      send_vertex(1'b0, 64'h8000_0000_0000_0000, 64'h0, 64'h0);
      send_vertex(1'b0, {32'h4000_0000, 32'd1023}, board.pos_y[1023], 64'h0);
      send_vertex(1'b0, 64'h7FF8_0000_0000_0000, 64'h0, 64'h0);
      drain();  // sender pauses until every response is back

      // Random meshes: new mesh every so often, mostly pooled coordinates.
      for (int n = 0; n < 510; n++) begin
         cx = pick_coord();
         cy = pick_coord();
         cz = pick_coord();
         send_vertex($urandom_range(0, 99) < 4, cx, cy, cz);
      end
      drain();
      repeat (50) @(posedge clock);

      $display("covered %0d new, %0d merged, %0d table-full responses",
               board.n_new, board.n_hit, board.n_full);
      if (board.errors == 0 && board.pending_rsp.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

FILE: vertex_dedup_table.f
src/vdt_pkg.sv
src/vdt_stream_if.sv
src/vdt_ram.sv
src/vdt_datapath.sv
src/vdt_ctrl.sv
src/vertex_dedup_table.sv
sim/vertex_dedup_table_tb.sv
